>>> src/wfs_pkg.sv
// Shared types, codes and reset values for the watchdog feed supervisor.
package wfs_pkg;

  localparam int unsigned FuncW      = 3;
  localparam int unsigned PktW       = 32;
  localparam int unsigned TimeoutW   = 20;
  localparam int unsigned IntervalW  = 8;
  localparam int unsigned ThreshW    = 16;
  localparam int unsigned MissW      = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 20;

  localparam logic [TimeoutW-1:0]  TimeoutReset   = 20'd3000;
  localparam logic [IntervalW-1:0] IntervalReset  = 8'd50;
  localparam logic [ThreshW-1:0]   ThreshReset    = 16'd200;
  localparam logic [MissW-1:0]     FallbackReset  = 16'd300;
  localparam logic [MissW-1:0]     MissMax        = 16'hFFFF;

  // Command codes carried in func.
  typedef enum logic [FuncW-1:0] {
    FUNC_TICK      = 3'd0,
    FUNC_KEEPALIVE = 3'd1,
    FUNC_ENABLE    = 3'd2,
    FUNC_DISABLE   = 3'd3,
    FUNC_REBOOT    = 3'd4
  } func_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT  = 2'd0,
    CFG_INTERVAL = 2'd1,
    CFG_THRESH   = 2'd2,
    CFG_FALLBACK = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [TimeoutW-1:0]  timeout_ticks;
    logic [IntervalW-1:0] free_interval;
    logic [ThreshW-1:0]   packet_threshold;
    logic [MissW-1:0]     fallback_misses;
  } cfg_t;

  typedef struct packed {
    logic feed;
    logic halted;
    logic unsupported;
  } result_t;

  // Result handoff from the decision logic to the result queue.
  typedef struct packed {
    logic    push;
    result_t res;
  } res_push_t;

endpackage

>>> src/wfs_if.sv
// Handshake channel interfaces: event input, result output, configuration write.
interface wfs_in_if import wfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FuncW-1:0]  func;
  logic [PktW-1:0]   packet_count;

  modport source (output valid, output func, output packet_count, input ready);
  modport sink   (input valid, input func, input packet_count, output ready);
endinterface

interface wfs_out_if;
  logic valid;
  logic ready;
  logic feed;
  logic halted;
  logic unsupported;

  modport source (output valid, output feed, output halted, output unsupported, input ready);
  modport sink   (input valid, input feed, input halted, input unsupported, output ready);
endinterface

interface wfs_cfg_if import wfs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/wfs_cfg.sv
// Configuration register file for the watchdog feed supervisor.
module wfs_cfg import wfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  wfs_cfg_if.sink           cfg_i,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid & cfg_i.ready;

  // Decode the write into the addressed register.
  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_TIMEOUT:  cfg_d.timeout_ticks    = cfg_i.data[TimeoutW-1:0];
        CFG_INTERVAL: cfg_d.free_interval    = cfg_i.data[IntervalW-1:0];
        CFG_THRESH:   cfg_d.packet_threshold = cfg_i.data[ThreshW-1:0];
        CFG_FALLBACK: cfg_d.fallback_misses  = cfg_i.data[MissW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks    <= TimeoutReset;
      cfg_q.free_interval    <= IntervalReset;
      cfg_q.packet_threshold <= ThreshReset;
      cfg_q.fallback_misses  <= FallbackReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/wfs_core.sv
// Per-item decision logic and supervisor state.
module wfs_core import wfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [FuncW-1:0]  func_i,
  input  logic [PktW-1:0]   packet_count_i,
  input  cfg_t              cfg_i,
  output res_push_t         push_o
);

  logic                 supervise_on_q, supervise_on_d;
  logic                 reboot_pending_q, reboot_pending_d;
  logic                 halt_q, halt_d;
  logic                 keepalive_q, keepalive_d;
  logic [TimeoutW-1:0]  tick_count_q, tick_count_d;
  logic [IntervalW-1:0] phase_q, phase_d;
  logic [PktW-1:0]      packet_mark_q, packet_mark_d;
  logic [MissW-1:0]     miss_q, miss_d;

  logic [PktW-1:0]      pkt_diff;
  logic [IntervalW:0]   phase_inc;
  logic [MissW-1:0]     miss_inc;
  logic                 want;
  logic                 stepped;
  logic                 feed;

  assign pkt_diff  = packet_count_i - packet_mark_q;
  assign phase_inc = {1'b0, phase_q} + {{IntervalW{1'b0}}, 1'b1};
  assign miss_inc  = miss_q + {{(MissW-1){1'b0}}, 1'b1};
  assign stepped   = (miss_q != MissMax);

  // Update state for the accepted item and decide on a feed.
  always_comb begin
    supervise_on_d   = supervise_on_q;
    reboot_pending_d = reboot_pending_q;
    halt_d           = halt_q;
    keepalive_d      = keepalive_q;
    tick_count_d     = tick_count_q;
    phase_d          = phase_q;
    packet_mark_d    = packet_mark_q;
    miss_d           = miss_q;
    want             = 1'b0;
    feed             = 1'b0;
    if (accept_i && !halt_q) begin
      case (func_e'(func_i))
        FUNC_TICK: begin
          // Pick the feed reason.
          if (!supervise_on_q) begin
            tick_count_d = '0;
            phase_d      = '0;
            want         = 1'b1;
          end else if (keepalive_q) begin
            keepalive_d   = 1'b0;
            packet_mark_d = packet_count_i;
            tick_count_d  = '0;
            phase_d       = '0;
            want          = 1'b1;
          end else if (tick_count_q < cfg_i.timeout_ticks) begin
            want         = (phase_q == '0);
            tick_count_d = tick_count_q + {{(TimeoutW-1){1'b0}}, 1'b1};
            if (phase_inc >= {1'b0, cfg_i.free_interval}) begin
              phase_d = '0;
            end else begin
              phase_d = phase_inc[IntervalW-1:0];
            end
          end else if (pkt_diff > {{(PktW-ThreshW){1'b0}}, cfg_i.packet_threshold}) begin
            tick_count_d  = '0;
            phase_d       = '0;
            packet_mark_d = packet_count_i;
            want          = 1'b1;
          end
          // Feed, or count a miss and maybe rescue.
          if (want && !reboot_pending_q) begin
            miss_d = '0;
            feed   = 1'b1;
          end else begin
            if (stepped) begin
              miss_d = miss_inc;
            end
            if (reboot_pending_q) begin
              halt_d = 1'b1;
            end else begin
              feed = stepped && (miss_inc == cfg_i.fallback_misses);
            end
          end
        end
        FUNC_KEEPALIVE: keepalive_d      = 1'b1;
        FUNC_ENABLE:    supervise_on_d   = 1'b1;
        FUNC_DISABLE:   supervise_on_d   = 1'b0;
        FUNC_REBOOT:    reboot_pending_d = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supervise_on_q   <= 1'b0;
      reboot_pending_q <= 1'b0;
      halt_q           <= 1'b0;
      keepalive_q      <= 1'b0;
      tick_count_q     <= '0;
      phase_q          <= '0;
      packet_mark_q    <= '0;
      miss_q           <= '0;
    end else begin
      supervise_on_q   <= supervise_on_d;
      reboot_pending_q <= reboot_pending_d;
      halt_q           <= halt_d;
      keepalive_q      <= keepalive_d;
      tick_count_q     <= tick_count_d;
      phase_q          <= phase_d;
      packet_mark_q    <= packet_mark_d;
      miss_q           <= miss_d;
    end
  end

  // Hand the result to the queue; codes above the reboot request are unsupported.
  always_comb begin
    push_o.push            = accept_i;
    push_o.res.feed        = feed;
    push_o.res.halted      = halt_d;
    push_o.res.unsupported = (func_i > FUNC_REBOOT);
  end

endmodule

>>> src/wfs_outbuf.sv
// Two-entry result queue between the decision logic and the output channel.
module wfs_outbuf import wfs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_push_t push_i,
  output logic      space_o,
  wfs_out_if.source out_o
);

  logic [1:0] cnt_q, cnt_d;
  result_t    head_q, head_d;
  result_t    tail_q, tail_d;
  logic       pop;

  assign pop     = out_o.valid & out_o.ready;
  assign space_o = (cnt_q != 2'd2);

  // Shift and fill the two slots.
  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    tail_d = tail_q;
    case ({push_i.push, pop})
      2'b10: begin
        if (cnt_q == 2'd0) begin
          head_d = push_i.res;
        end else begin
          tail_d = push_i.res;
        end
        cnt_d = cnt_q + 2'd1;
      end
      2'b01: begin
        head_d = tail_q;
        cnt_d  = cnt_q - 2'd1;
      end
      2'b11: begin
        if (cnt_q == 2'd1) begin
          head_d = push_i.res;
        end else begin
          head_d = tail_q;
          tail_d = push_i.res;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign out_o.valid       = (cnt_q != 2'd0);
  assign out_o.feed        = head_q.feed;
  assign out_o.halted      = head_q.halted;
  assign out_o.unsupported = head_q.unsupported;

endmodule

>>> src/watchdog_feed_supervisor.sv
// Top level of the watchdog feed supervisor.
// Takes one event item (tick or command) per clock and returns one result item for each,
// in order; a result is visible on the output channel at the earliest the cycle after its
// item is accepted, later when older results are still waiting in the queue.
// The feed decision and next counter and flag values are combinational, so the sustained
// rate is one item per cycle; a two-entry result queue lets input keep flowing while one
// result waits, and input stalls only when both entries are full. Configuration writes
// are taken in any cycle and should be issued only while the block is idle.
module watchdog_feed_supervisor import wfs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  wfs_in_if.sink    in_i,
  wfs_out_if.source out_o,
  wfs_cfg_if.sink   cfg_i
);

  cfg_t      cfg;
  res_push_t push;
  logic      space;
  logic      accept;

  assign in_i.ready = space;
  assign accept     = in_i.valid & space;

  wfs_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  wfs_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .func_i         (in_i.func),
    .packet_count_i (in_i.packet_count),
    .cfg_i          (cfg),
    .push_o         (push)
  );

  wfs_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule

>>> src/wfs_checker.sv
// Port-level checks for the watchdog feed supervisor, bound to the top level.
module wfs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_feed_i,
  input logic out_halted_i,
  input logic out_unsupported_i
);

  logic halt_seen_q;

  // Remember that a halted result has been delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halt_seen_q <= 1'b0;
    end else if (out_valid_i && out_ready_i && out_halted_i) begin
      halt_seen_q <= 1'b1;
    end
  end

  // Once halted, every later result stays halted and never feeds.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && halt_seen_q |-> out_halted_i && !out_feed_i)
    else $error("result after halt is not halted or feeds");

  // A halted result never feeds.
  a_halt_no_feed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_halted_i |-> !out_feed_i)
    else $error("halted result carries a feed");

  // Input stalls only while results are queued.
  a_stall_needs_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no pending result");

  // An accepted item shows a result on the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("no result after accepted item");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_feed_i)
      && $stable(out_halted_i) && $stable(out_unsupported_i))
    else $error("stalled result changed");

endmodule

bind watchdog_feed_supervisor wfs_checker u_wfs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_feed_i        (out_o.feed),
  .out_halted_i      (out_o.halted),
  .out_unsupported_i (out_o.unsupported)
);

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the watchdog feed supervisor: directed table, then random phases.
module testbench;
  import wfs_pkg::*;

  // Command codes the block reports as unsupported.
  localparam logic [FuncW-1:0] FuncUnsupLo  = 3'd5;
  localparam logic [FuncW-1:0] FuncUnsupMid = 3'd6;
  localparam logic [FuncW-1:0] FuncUnsupHi  = 3'd7;

  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned PhaseItems   = 100;
  localparam int unsigned ClosingItems = 40;
  localparam int unsigned LongHold     = 90;
  localparam int unsigned HoldAfter    = 250;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PrintCap     = 40;

  localparam result_t ResFed    = '{feed: 1'b1, halted: 1'b0, unsupported: 1'b0};
  localparam result_t ResQuiet  = '{feed: 1'b0, halted: 1'b0, unsupported: 1'b0};
  localparam result_t ResUnsup  = '{feed: 1'b0, halted: 1'b0, unsupported: 1'b1};
  localparam result_t ResHalted = '{feed: 1'b0, halted: 1'b1, unsupported: 1'b0};

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [PktW-1:0]  pkts;
    logic             typed;
    result_t          want;
  } dir_row_t;

  typedef struct packed {
    logic                 enabled;
    logic                 reboot;
    logic                 halted;
    logic                 keepalive;
    logic [TimeoutW-1:0]  ticks;
    logic [IntervalW-1:0] phase;
    logic [PktW-1:0]      mark;
    logic [MissW-1:0]     misses;
  } sup_state_t;

  localparam int unsigned DirRows = 20;

  // Directed rows run on reset settings; typed rows carry an obvious result.
  dir_row_t dir_table [DirRows] = '{
    '{FUNC_TICK,      32'h0000_0000, 1'b1, ResFed},
    '{FUNC_TICK,      32'hFFFF_FFFF, 1'b1, ResFed},
    '{FuncUnsupLo,    32'h0000_0000, 1'b1, ResUnsup},
    '{FuncUnsupMid,   32'hFFFF_FFFF, 1'b1, ResUnsup},
    '{FuncUnsupHi,    32'h5555_5555, 1'b1, ResUnsup},
    '{FUNC_KEEPALIVE, 32'h0000_0000, 1'b1, ResQuiet},
    '{FUNC_ENABLE,    32'h0000_0000, 1'b1, ResQuiet},
    '{FUNC_TICK,      32'hAAAA_AAAA, 1'b0, ResQuiet},
    '{FUNC_TICK,      32'hAAAA_AAAA, 1'b0, ResQuiet},
    '{FUNC_TICK,      32'hAAAA_AAAB, 1'b0, ResQuiet},
    '{FUNC_DISABLE,   32'h0000_0000, 1'b1, ResQuiet},
    '{FUNC_TICK,      32'h0000_0000, 1'b0, ResQuiet},
    '{FUNC_ENABLE,    32'h0000_0000, 1'b1, ResQuiet},
    '{FUNC_TICK,      32'h0000_0010, 1'b0, ResQuiet},
    '{FUNC_TICK,      32'h0000_0020, 1'b0, ResQuiet},
    '{FUNC_KEEPALIVE, 32'hFFFF_FFFF, 1'b1, ResQuiet},
    '{FUNC_KEEPALIVE, 32'h0000_0000, 1'b1, ResQuiet},
    '{FUNC_TICK,      32'hFFFF_FFFF, 1'b0, ResQuiet},
    '{FUNC_TICK,      32'h0000_00C8, 1'b0, ResQuiet},
    '{FUNC_TICK,      32'h0000_00C9, 1'b0, ResQuiet}
  };

  logic clk;
  logic rst_n;

  wfs_in_if  in_if ();
  wfs_out_if out_if ();
  wfs_cfg_if cfg_if ();

  watchdog_feed_supervisor i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  cfg_t        sup_cfg;
  sup_state_t  sup;
  result_t     pending_results [$];
  logic [PktW-1:0] pkt_run;
  int unsigned err_count      = 0;
  int unsigned items_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned feeds_seen     = 0;
  int unsigned halted_seen    = 0;
  int unsigned settings_count = 0;
  bit          calm           = 1'b0;
  bit          long_hold_done = 1'b0;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < PrintCap) $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Tick decision: update timing, mark and miss count, return the feed bit.
  function automatic logic decide_tick_feed(input logic [PktW-1:0] pkts);
    logic            want;
    logic            stepped;
    logic [PktW-1:0] delta;
    want    = 1'b0;
    stepped = 1'b0;
    delta   = pkts - sup.mark;
    if (!sup.enabled) begin
      sup.ticks = '0;
      sup.phase = '0;
      want      = 1'b1;
    end else if (sup.keepalive) begin
      sup.keepalive = 1'b0;
      sup.mark      = pkts;
      sup.ticks     = '0;
      sup.phase     = '0;
      want          = 1'b1;
    end else if (sup.ticks < sup_cfg.timeout_ticks) begin
      if (sup.phase == '0) want = 1'b1;
      sup.ticks = sup.ticks + 1'b1;
      // An interval of zero, or one lowered below the phase, wraps to zero here.
      if ({1'b0, sup.phase} + 9'd1 >= {1'b0, sup_cfg.free_interval}) sup.phase = '0;
      else sup.phase = sup.phase + 1'b1;
    end else if (delta > {{(PktW-ThreshW){1'b0}}, sup_cfg.packet_threshold}) begin
      sup.ticks = '0;
      sup.phase = '0;
      sup.mark  = pkts;
      want      = 1'b1;
    end
    if (want && !sup.reboot) begin
      sup.misses = '0;
      return 1'b1;
    end
    // Saturate the miss count; rescue only on the step that lands on the fallback.
    if (sup.misses != MissMax) begin
      sup.misses = sup.misses + 1'b1;
      stepped    = 1'b1;
    end
    if (sup.reboot) begin
      sup.halted = 1'b1;
      return 1'b0;
    end
    return stepped && (sup.misses == sup_cfg.fallback_misses);
  endfunction

  function automatic result_t predict_result(input logic [FuncW-1:0] f,
                                             input logic [PktW-1:0] pkts);
    result_t r;
    r             = '0;
    r.unsupported = (f >= FuncUnsupLo);
    if (!sup.halted) begin
      case (f)
        FUNC_TICK:      r.feed = decide_tick_feed(pkts);
        FUNC_KEEPALIVE: sup.keepalive = 1'b1;
        FUNC_ENABLE:    sup.enabled = 1'b1;
        FUNC_DISABLE:   sup.enabled = 1'b0;
        FUNC_REBOOT:    sup.reboot = 1'b1;
        default:        ;
      endcase
    end
    r.halted = sup.halted;
    return r;
  endfunction

  // Offer one item after a random gap; queue its expected result on acceptance.
  task automatic send_item(input logic [FuncW-1:0] f, input logic [PktW-1:0] pkts,
                           input logic typed, input result_t want);
    int unsigned gap;
    result_t     exp;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.func         <= f;
    in_if.packet_count <= pkts;
    do @(posedge clk); while (!in_if.ready);
    exp = predict_result(f, pkts);
    pending_results.push_back(typed ? want : exp);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_TIMEOUT:  sup_cfg.timeout_ticks    = value[TimeoutW-1:0];
      CFG_INTERVAL: sup_cfg.free_interval    = value[IntervalW-1:0];
      CFG_THRESH:   sup_cfg.packet_threshold = value[ThreshW-1:0];
      CFG_FALLBACK: sup_cfg.fallback_misses  = value[MissW-1:0];
      default:      ;
    endcase
    @(negedge clk);
  endtask

  // Write all four registers once the block has gone idle.
  task automatic apply_settings(input logic [TimeoutW-1:0] timeout,
                                input logic [IntervalW-1:0] interval,
                                input logic [ThreshW-1:0] thresh,
                                input logic [MissW-1:0] fallback);
    hold_until_drained();
    repeat (SettleCycles) @(negedge clk);
    write_reg(CFG_TIMEOUT,  CfgDataW'(timeout));
    write_reg(CFG_INTERVAL, CfgDataW'(interval));
    write_reg(CFG_THRESH,   CfgDataW'(thresh));
    write_reg(CFG_FALLBACK, CfgDataW'(fallback));
    cfg_if.valid <= 1'b0;
    settings_count++;
  endtask

  task automatic apply_random_settings();
    apply_settings(TimeoutW'($urandom_range(1, 40)), IntervalW'($urandom_range(1, 12)),
                   ThreshW'($urandom_range(0, 400)), MissW'($urandom_range(1, 25)));
  endtask

  // Packet totals mostly creep up around the threshold, sometimes jump anywhere.
  function automatic logic [PktW-1:0] next_packets();
    if ($urandom_range(0, 9) == 0) return $urandom;
    pkt_run = pkt_run + $urandom_range(0, sup_cfg.packet_threshold / 2 + 4);
    return pkt_run;
  endfunction

  // One random phase: mostly ticks with supervision on, plus commands and noise.
  task automatic run_phase(input logic [PktW-1:0] pkt_start, input bit no_idle);
    int unsigned      n;
    int unsigned      r;
    logic [FuncW-1:0] f;
    calm    = no_idle;
    pkt_run = pkt_start;
    for (n = 0; n < PhaseItems; n++) begin
      if (n == PhaseItems / 2) hold_until_drained();
      r = $urandom_range(0, 99);
      if (r < 70) f = FUNC_TICK;
      else if (r < 80) f = FUNC_KEEPALIVE;
      else if (r < 87) f = FUNC_ENABLE;
      else if (r < 92) f = FUNC_DISABLE;
      else f = FuncUnsupLo + FuncW'($urandom_range(0, FuncUnsupHi - FuncUnsupLo));
      send_item(f, next_packets(), 1'b0, ResQuiet);
    end
    calm = 1'b0;
  endtask

  // Result side: random stalls, plus one long hold to fill the block.
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_seen >= HoldAfter) begin
        stall_left     = LongHold;
        long_hold_done = 1'b1;
      end
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (!calm) stall_left = pick_gap();
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_results.pop_front();
        if (out_if.feed !== want.feed)
          report_mismatch($sformatf("result %0d feed got %b want %b",
                                    results_seen, out_if.feed, want.feed));
        if (out_if.halted !== want.halted)
          report_mismatch($sformatf("result %0d halted got %b want %b",
                                    results_seen, out_if.halted, want.halted));
        if (out_if.unsupported !== want.unsupported)
          report_mismatch($sformatf("result %0d unsupported got %b want %b",
                                    results_seen, out_if.unsupported, want.unsupported));
      end
      if (out_if.feed === 1'b1) feeds_seen++;
      if (out_if.halted === 1'b1) halted_seen++;
    end
  end

  // End the run when no handshake has happened for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no handshake for %0d cycles", IdleLimit);
    $display("== FAIL ==");
    $finish;
  end

  // Reset, directed table, random phases, then reboot and halt.
  initial begin
    int unsigned k;
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.func         = FUNC_TICK;
    in_if.packet_count = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_TIMEOUT;
    cfg_if.data        = '0;
    sup_cfg            = '{TimeoutReset, IntervalReset, ThreshReset, FallbackReset};
    sup                = '0;
    pkt_run            = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (k = 0; k < DirRows; k++) begin
      send_item(dir_table[k].func, dir_table[k].pkts, dir_table[k].typed, dir_table[k].want);
    end

    apply_settings(20'd4, 8'd3, 16'd10, 16'd5);
    run_phase(32'h0000_0100, 1'b0);
    // Timeout and interval of one: every timed tick is free until the first timeout.
    apply_settings(20'd1, 8'd1, 16'd0, 16'd1);
    run_phase($urandom, 1'b0);
    // Back-to-back traffic; the result side holds off here and fills the block.
    apply_random_settings();
    run_phase($urandom, 1'b1);
    // Zero timeout, zero interval and zero fallback: no free feed, no rescue.
    apply_settings(20'd0, 8'd0, 16'hFFFF, 16'd0);
    run_phase($urandom, 1'b0);
    apply_settings(20'hFFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    run_phase($urandom, 1'b0);
    apply_random_settings();
    run_phase($urandom, 1'b0);
    // Start just below the wrap so packet differences cross 2^32.
    apply_random_settings();
    run_phase(32'hFFFF_FF80, 1'b0);

    // Request reboot; the next tick stops feeding for good.
    send_item(FUNC_ENABLE, 32'h0, 1'b0, ResQuiet);
    send_item(FUNC_REBOOT, 32'h0, 1'b0, ResQuiet);
    send_item(FUNC_KEEPALIVE, 32'h0, 1'b0, ResQuiet);
    send_item(FuncUnsupHi, 32'h0, 1'b0, ResQuiet);
    send_item(FUNC_TICK, $urandom, 1'b1, ResHalted);
    for (k = 0; k < ClosingItems; k++) begin
      send_item(FuncW'($urandom_range(0, 7)), $urandom, 1'b0, ResQuiet);
    end

    hold_until_drained();
    repeat (SettleCycles) @(posedge clk);
    $display("covered %0d items under %0d register settings, %0d results, %0d feeds",
             items_sent, settings_count, results_seen, feeds_seen);
    $display("reboot reached the halted state, %0d results reported halted, %0d mismatches",
             halted_seen, err_count);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
